// File: rtl/assert_macros.svh
// Assertion helpers shared by the modules that check themselves
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ACD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define ACD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/acd_pkg.sv
// ----------------------------------------------------------------------------
// acd_pkg
// Types, constants and functions shared by the AES-CBC decryptor modules.
// ----------------------------------------------------------------------------
package acd_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned RkDepth    = 30;
  localparam int unsigned RkAw       = 5;
  localparam int unsigned QDepth     = 2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPAD = 2'd1,
    ST_NOCT   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_KEY_SIZE = 3'd0,
    CFG_KEY_W0   = 3'd1,
    CFG_KEY_W1   = 3'd2,
    CFG_KEY_W2   = 3'd3,
    CFG_KEY_W3   = 3'd4
  } cfg_idx_t;

  // Classified request handed from the front part to the back part
  typedef struct packed {
    logic [127:0] ct;
    logic [127:0] iv;
    logic         last;
    logic         noct;
  } job_t;

  // Key schedule status between key expander and core
  typedef struct packed {
    logic       busy;
    logic [3:0] nr;
  } ks_stat_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // Inverse MixColumns of one column, a0 in the top byte
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int i = 0; i < 4; i++) begin
      a[i]  = c[31-8*i -: 8];
      x2[i] = xt(a[i]);
      x4[i] = xt(x2[i]);
      x8[i] = xt(x4[i]);
      m9[i] = x8[i] ^ a[i];
      mb[i] = x8[i] ^ x2[i] ^ a[i];
      md[i] = x8[i] ^ x4[i] ^ a[i];
      me[i] = x8[i] ^ x4[i] ^ x2[i];
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

  // Inverse ShiftRows then inverse SubBytes; byte j of the state at [127-8j]
  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*((c+r)%4)) -: 8] = inv_sbox(s[127-8*(r+4*c) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    return {inv_mix_col(s[127:96]), inv_mix_col(s[95:64]),
            inv_mix_col(s[63:32]), inv_mix_col(s[31:0])};
  endfunction

endpackage

// File: rtl/acd_ram.sv
// ----------------------------------------------------------------------------
// acd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module acd_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 30
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/acd_keyexp.sv
// ----------------------------------------------------------------------------
// acd_keyexp
// Holds key registers and expands the key, one 32-bit word a cycle while no
// configuration write arrives, into two round key RAMs (high and low word of each entry).
// ----------------------------------------------------------------------------
module acd_keyexp
  import acd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [63:0]     cfg_wdata,
  input  logic [RkAw-1:0] rk_raddr,
  output logic [63:0]     rk_rdata,
  output ks_stat_t        ks_stat
);

  logic [1:0]  key_size_r;
  logic [63:0] kw_r [4];
  logic        busy_r;
  logic [5:0]  idx_r;
  logic [2:0]  cnt_r;
  logic [7:0]  rc_r;
  logic [31:0] win_r [8];

  logic [1:0]  eff;
  logic [3:0]  nk;
  logic [5:0]  total;
  logic [31:0] t;
  logic [31:0] wnew;
  logic        we_h;
  logic        we_l;
  logic        hit;
  logic [63:0] rd_h;
  logic [63:0] rd_l;

  assign eff   = (key_size_r == 2'd3) ? 2'd2 : key_size_r;
  assign nk    = 4'd4 + {1'b0, eff, 1'b0};
  assign total = {nk, 2'b00} + 6'd28;

  // Key word recurrence; the window holds the last nk words, oldest at index 0
  always_comb begin
    t   = win_r[nk[2:0] - 3'd1];
    hit = (cnt_r == 3'd0);
    if (hit) begin
      t = sub_word({t[23:0], t[31:24]}) ^ {rc_r, 24'h0};
    end else if (nk == 4'd8 && cnt_r == 3'd4) begin
      t = sub_word(t);
    end
    wnew = win_r[0] ^ t;
  end

  // Hold key registers, run the expansion after each write to the key size or a key word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_size_r <= 2'd0;
      for (int i = 0; i < 4; i++) kw_r[i] <= '0;
      busy_r <= 1'b0;
      idx_r  <= '0;
      cnt_r  <= '0;
      rc_r   <= 8'h01;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KEY_SIZE: key_size_r <= cfg_wdata[1:0];
        CFG_KEY_W0:   kw_r[0] <= cfg_wdata;
        CFG_KEY_W1:   kw_r[1] <= cfg_wdata;
        CFG_KEY_W2:   kw_r[2] <= cfg_wdata;
        CFG_KEY_W3:   kw_r[3] <= cfg_wdata;
        default: ;
      endcase
      if (cfg_index <= 3'd4) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
        rc_r   <= 8'h01;
      end
    end else if (busy_r) begin
      if (idx_r == total - 6'd1) busy_r <= 1'b0;
      idx_r <= idx_r + 6'd1;
      if (idx_r >= {2'b00, nk}) begin
        cnt_r <= (cnt_r == nk[2:0] - 3'd1 || (nk == 4'd8 && cnt_r == 3'd7)) ? 3'd0
                 : cnt_r + 3'd1;
        if (hit) rc_r <= xt(rc_r);
      end else if (idx_r == {2'b00, nk} - 6'd1) begin
        cnt_r <= 3'd0;
      end
    end
  end

  // Shift window: load the whole key at the start, then append each new word
  always_ff @(posedge clk) begin
    if (busy_r && !cfg_we) begin
      if (idx_r < {2'b00, nk}) begin
        if (idx_r == '0) begin
          for (int i = 0; i < 8; i++) win_r[i] <= kw_r[i/2][63-32*(i%2) -: 32];
        end
      end else begin
        for (int i = 0; i < 7; i++) begin
          if (i + 1 < int'(nk)) win_r[i] <= win_r[i+1];
        end
        win_r[nk[2:0] - 3'd1] <= wnew;
      end
    end
  end

  logic [31:0] wout;
  assign wout = (idx_r < {2'b00, nk}) ? kw_r[idx_r[2:1]][63-32*idx_r[0] -: 32] : wnew;
  assign we_h = busy_r && !cfg_we && !idx_r[0];
  assign we_l = busy_r && !cfg_we && idx_r[0];

  acd_ram #(.Width(64), .Depth(RkDepth)) u_rk_h (
    .clk(clk), .we(we_h), .waddr(idx_r[5:1]), .wdata({wout, 32'h0}),
    .raddr(rk_raddr), .rdata(rd_h)
  );

  acd_ram #(.Width(64), .Depth(RkDepth)) u_rk_l (
    .clk(clk), .we(we_l), .waddr(idx_r[5:1]), .wdata({32'h0, wout}),
    .raddr(rk_raddr), .rdata(rd_l)
  );

  assign rk_rdata     = {rd_h[63:32], rd_l[31:0]};
  assign ks_stat.busy = busy_r;
  assign ks_stat.nr   = 4'd10 + {1'b0, eff, 1'b0};

endmodule

// File: rtl/acd_front.sv
// ----------------------------------------------------------------------------
// acd_front
// Accepts input blocks, tracks IV and chaining, and queues decryption jobs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module acd_front
  import acd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        in_block_last,
  output logic        q_valid,
  input  logic        q_pop,
  output job_t        q_head
);

  job_t        q_r [QDepth];
  logic [1:0]  cnt_r;
  logic        rd_r;
  logic        wr_r;
  logic        await_r;
  logic [127:0] chain_r;
  logic        acc;
  logic        push;
  job_t        job;

  assign in_ready = (cnt_r != 2'd2);
  assign acc      = in_valid && in_ready;
  assign push     = acc && (!await_r || in_block_last);
  assign job.ct   = {in_block_high, in_block_low};
  assign job.iv   = chain_r;
  assign job.last = in_block_last;
  assign job.noct = await_r;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_head   = q_r[rd_r];

  // Track IV state and chaining block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r <= 1'b1;
      chain_r <= '0;
    end else if (acc) begin
      chain_r <= {in_block_high, in_block_low};
      await_r <= in_block_last;
    end
  end

  // Job queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push) begin
        q_r[wr_r] <= job;
        wr_r <= ~wr_r;
      end
      if (q_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  `ACD_ASSERT_IMP(a_no_overflow, clk, rst_n, push, cnt_r != 2'd2 || q_pop,
                  "job queue overflow")
  `ACD_ASSERT_IMP(a_no_underflow, clk, rst_n, q_pop, cnt_r != 2'd0,
                  "job queue underflow")

endmodule

// File: rtl/acd_back.sv
// ----------------------------------------------------------------------------
// acd_back
// Runs the AES inverse cipher one round at a time, one block at a time, chains and unpads.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module acd_back
  import acd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_pop,
  input  job_t            q_head,
  output logic [RkAw-1:0] rk_raddr,
  input  logic [63:0]     rk_rdata,
  input  ks_stat_t        ks_stat,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [63:0]     out_plain_high,
  output logic [63:0]     out_plain_low,
  output logic            out_plain_last,
  output logic [4:0]      out_valid_bytes,
  output logic [1:0]      out_status
);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_ROUND, S_DONE} state_t;

  state_t       state_r;
  logic [3:0]   rnd_r;
  logic [127:0] st_r;
  job_t         job_r;
  logic         ov_r;
  logic [127:0] ob_r;
  logic         ol_r;
  logic [4:0]   ovb_r;
  logic [1:0]   ost_r;

  logic [127:0] rk;
  logic [127:0] ss;
  logic [127:0] ark;
  logic [127:0] pt;
  logic [7:0]   pad;
  logic         pad_ok;
  logic [4:0]   vb;
  status_t      st;
  logic         out_free;

  // Two entries read in consecutive cycles: the high half, then the low half
  logic         half_r;
  logic [63:0]  rk_hi_r;

  assign out_free = !ov_r || out_ready;
  assign rk       = {rk_hi_r, rk_rdata};
  assign ss       = inv_shift_sub(st_r);
  assign ark      = ss ^ rk;
  assign pt       = st_r ^ job_r.iv;
  assign pad      = pt[7:0];

  // Round key address, issued ahead of use since the RAM registers the read: entry 2r, then 2r+1
  always_comb begin
    case (state_r)
      S_IDLE:  rk_raddr = RkAw'({ks_stat.nr, 1'b0});
      S_ROUND: begin
        if (half_r) rk_raddr = RkAw'({rnd_r, 1'b1});
        else if (rnd_r == 4'd0) rk_raddr = '0;
        else rk_raddr = RkAw'({rnd_r - 4'd1, 1'b0});
      end
      default: rk_raddr = RkAw'({rnd_r, 1'b1});
    endcase
  end

  // Check the padding on the final plaintext
  always_comb begin
    pad_ok = (pad >= 8'd1) && (pad <= 8'd16);
    for (int j = 0; j < 16; j++) begin
      if (j < int'(pad) && pt[8*j +: 8] != pad) pad_ok = 1'b0;
    end
    vb = 5'd16;
    st = ST_OK;
    if (job_r.last) begin
      if (pad_ok) vb = 5'd16 - pad[4:0];
      else begin
        vb = 5'd0;
        st = ST_BADPAD;
      end
    end
  end

  assign q_pop = (state_r == S_IDLE) && q_valid && !ks_stat.busy;

  // Sequencer: fetch key halves, then for each round apply it and latch the next high key half
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      half_r  <= 1'b0;
      rnd_r   <= '0;
    end else begin
      if (ov_r && out_ready && state_r != S_DONE) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            job_r  <= q_head;
            rnd_r  <= ks_stat.nr;
            half_r <= 1'b0;
            state_r <= q_head.noct ? S_DONE : S_FETCH;
          end
        end
        S_FETCH: begin
          rk_hi_r <= rk_rdata;
          half_r  <= 1'b0;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          if (!half_r) begin
            // Apply the round with the full round key
            if (rnd_r == ks_stat.nr) st_r <= job_r.ct ^ rk;
            else if (rnd_r == 4'd0) st_r <= ark;
            else st_r <= inv_mix(ark);
            if (rnd_r == 4'd0) begin
              state_r <= S_DONE;
            end else begin
              rnd_r  <= rnd_r - 4'd1;
              half_r <= 1'b1;
            end
          end else begin
            // Latch the high half of the next round key
            rk_hi_r <= rk_rdata;
            half_r  <= 1'b0;
          end
        end
        S_DONE: begin
          if (out_free) begin
            ov_r    <= 1'b1;
            ol_r    <= job_r.last;
            if (job_r.noct) begin
              ob_r  <= '0;
              ovb_r <= 5'd0;
              ost_r <= ST_NOCT;
            end else begin
              ob_r  <= pt;
              ovb_r <= vb;
              ost_r <= st;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = ov_r;
  assign out_plain_high  = ob_r[127:64];
  assign out_plain_low   = ob_r[63:0];
  assign out_plain_last  = ol_r;
  assign out_valid_bytes = ovb_r;
  assign out_status      = ost_r;

  `ACD_ASSERT_NXT(a_out_hold, clk, rst_n, ov_r && !out_ready, ov_r,
                  "result dropped while stalled")
  `ACD_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, state_r == S_IDLE,
                  "job taken while busy")

endmodule

// File: rtl/aes_cbc_decrypt_unpad_top.sv
// Each ciphertext block passes Nr rounds (Nr = 10, 12, 14) in the shared round unit, which
// fetches two round key halves per round and works on one block at a time.
// An IV is only recorded; an IV marked last is queued and yields a result with no plaintext.
// A key write re-expands the key before decryption resumes.
// Reset (rst_n low, synchronous) clears control and awaits an IV.
// ----------------------------------------------------------------------------
// aes_cbc_decrypt_unpad_top
// AES-CBC decryptor with PKCS#7 padding check, front queue and round core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module aes_cbc_decrypt_unpad_top
  import acd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        in_block_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_plain_high,
  output logic [63:0] out_plain_low,
  output logic        out_plain_last,
  output logic [4:0]  out_valid_bytes,
  output logic [1:0]  out_status
);

  logic            q_valid;
  logic            q_pop;
  job_t            q_head;
  logic [RkAw-1:0] rk_raddr;
  logic [63:0]     rk_rdata;
  ks_stat_t        ks_stat;

  acd_keyexp u_keyexp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .rk_raddr, .rk_rdata, .ks_stat
  );

  acd_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_block_high, .in_block_low,
    .in_block_last, .q_valid, .q_pop, .q_head
  );

  acd_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_head, .rk_raddr, .rk_rdata, .ks_stat,
    .out_valid, .out_ready, .out_plain_high, .out_plain_low, .out_plain_last,
    .out_valid_bytes, .out_status
  );

endmodule

// File: test/aes_cbc_decrypt_unpad_top_tb.sv
// ----------------------------------------------------------------------------
// AES-CBC decryptor with PKCS#7 unpadding - testbench
// Drives parcels of 16-byte blocks through the decryptor. A model written
// here works out each plaintext block and its padding verdict, and every
// result is checked field by field in order. Parcels are mostly built so that
// the last block decrypts to chosen padding, with bad padding, IV-only parcels
// and raw blocks mixed in, over all key sizes and several idling patterns.
// ----------------------------------------------------------------------------
module aes_cbc_decrypt_unpad_top_tb;
  import acd_pkg::*;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PhaseItems  = 125;

  typedef struct {
    logic [63:0] ph;
    logic [63:0] pl;
    logic        last;
    logic [4:0]  vb;
    status_t     st;
  } plain_res_t;

  typedef struct {
    logic [127:0] blk;
    bit           last;
    bit           known;
    plain_res_t   res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_block_high = '0;
  logic [63:0] in_block_low = '0;
  logic        in_block_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_plain_high;
  logic [63:0] out_plain_low;
  logic        out_plain_last;
  logic [4:0]  out_valid_bytes;
  logic [1:0]  out_status;

  // Own copy of the decryptor state and key registers
  logic [7:0]   fwd_tab [256];
  logic [7:0]   inv_tab [256];
  logic [1:0]   key_len;
  logic [63:0]  key_reg [4];
  logic [63:0]  rnd_key [30];
  logic [127:0] chain_blk;
  bit           await_iv;

  plain_res_t plain_q [$];
  int         errors = 0;
  int         cycles = 0;
  int         snd_idle_pct = 0;
  int         rcv_stall_pct = 0;
  int         hold_cnt = 0;
  int         phase_items = 0;

  cfg_idx_t reg_ids [5] = '{CFG_KEY_SIZE, CFG_KEY_W0, CFG_KEY_W1, CFG_KEY_W2, CFG_KEY_W3};

  aes_cbc_decrypt_unpad_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_block_high  (in_block_high),
    .in_block_low   (in_block_low),
    .in_block_last  (in_block_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_plain_high (out_plain_high),
    .out_plain_low  (out_plain_low),
    .out_plain_last (out_plain_last),
    .out_valid_bytes(out_valid_bytes),
    .out_status     (out_status)
  );

  always #5 clk = ~clk;

  // GF(2^8) arithmetic for the S-box and InvMixColumns
  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = gf_dbl(a);
    end
    return r;
  endfunction

  // Build S-box and its inverse from the field inverse and the affine map
  task automatic build_boxes();
    logic [7:0] v;
    logic [7:0] s;
    for (int a = 0; a < 256; a++) begin
      v = '0;
      for (int b = 1; b < 256; b++) if (gf_mul(8'(a), 8'(b)) == 8'h01) v = 8'(b);
      s = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]} ^ {v[3:0], v[7:4]} ^ 8'h63;
      fwd_tab[a] = s;
      inv_tab[s] = 8'(a);
    end
  endtask

  function automatic int eff_len();
    return (key_len == 2'd3) ? 2 : int'(key_len);
  endfunction

  function automatic logic [31:0] sub_w(input logic [31:0] w);
    return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
  endfunction

  // Re-expand the key from the current registers
  task automatic expand_key();
    logic [31:0] w [60];
    logic [31:0] t;
    logic [7:0]  rc;
    int          nk;
    int          total;
    nk = 4 + 2 * eff_len();
    total = 4 * (nk + 7);
    rc = 8'h01;
    for (int i = 0; i < 4; i++) begin
      w[2*i]   = key_reg[i][63:32];
      w[2*i+1] = key_reg[i][31:0];
    end
    for (int i = nk; i < total; i++) begin
      t = w[i-1];
      if (i % nk == 0) begin
        t = sub_w({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_w(t);
      end
      w[i] = w[i-nk] ^ t;
    end
    for (int i = 0; i < 30; i++) rnd_key[i] = '0;
    for (int i = 0; i < total; i += 2) rnd_key[i/2] = {w[i], w[i+1]};
  endtask

  function automatic logic [127:0] round_key(input int rd);
    return {rnd_key[(2*rd) % 30], rnd_key[(2*rd+1) % 30]};
  endfunction

  function automatic logic [127:0] unshift_sub(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(r+4*((c+r)%4)) -: 8] = inv_tab[s[127-8*(r+4*c) -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] unmix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a [4];
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) a[i] = s[127-8*(4*c+i) -: 8];
      t[127-8*(4*c)   -: 8] = gf_mul(a[0], 8'd14) ^ gf_mul(a[1], 8'd11) ^
                              gf_mul(a[2], 8'd13) ^ gf_mul(a[3], 8'd9);
      t[127-8*(4*c+1) -: 8] = gf_mul(a[0], 8'd9) ^ gf_mul(a[1], 8'd14) ^
                              gf_mul(a[2], 8'd11) ^ gf_mul(a[3], 8'd13);
      t[127-8*(4*c+2) -: 8] = gf_mul(a[0], 8'd13) ^ gf_mul(a[1], 8'd9) ^
                              gf_mul(a[2], 8'd14) ^ gf_mul(a[3], 8'd11);
      t[127-8*(4*c+3) -: 8] = gf_mul(a[0], 8'd11) ^ gf_mul(a[1], 8'd13) ^
                              gf_mul(a[2], 8'd9) ^ gf_mul(a[3], 8'd14);
    end
    return t;
  endfunction

  function automatic logic [127:0] aes_inverse(input logic [127:0] c);
    logic [127:0] s;
    int           nr;
    nr = 10 + 2 * eff_len();
    s = c ^ round_key(nr);
    for (int rd = nr - 1; rd >= 1; rd--) s = unmix(unshift_sub(s) ^ round_key(rd));
    return unshift_sub(s) ^ round_key(0);
  endfunction

  // Advance the CBC chain by one block; hand back the plaintext result if any
  task automatic decrypt_step(input logic [127:0] b, input bit last,
                              output plain_res_t r, output bit has);
    logic [127:0] p;
    logic [7:0]   pad;
    bit           ok;
    has = 1'b1;
    if (await_iv) begin
      chain_blk = b;
      if (!last) begin
        await_iv = 1'b0;
        has = 1'b0;
      end else begin
        r = '{64'h0, 64'h0, 1'b1, 5'd0, ST_NOCT};
      end
      return;
    end
    p = aes_inverse(b) ^ chain_blk;
    chain_blk = b;
    r = '{p[127:64], p[63:0], last, 5'd16, ST_OK};
    if (last) begin
      pad = p[7:0];
      ok = (pad >= 1 && pad <= 16);
      for (int j = 0; j < 16; j++) if (j < pad && p[8*j +: 8] != pad) ok = 1'b0;
      if (ok) r.vb = 5'(16 - pad);
      else begin
        r.vb = 5'd0;
        r.st = ST_BADPAD;
      end
      await_iv = 1'b1;
    end
  endtask

  // Offer one request and wait until it is taken
  task automatic send_block(input logic [127:0] b, input bit last,
                            input bit known = 1'b0,
                            input plain_res_t typed = '{64'h0, 64'h0, 1'b0, 5'd0, ST_OK});
    plain_res_t r;
    bit         has;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_block_high <= b[127:64];
    in_block_low  <= b[63:0];
    in_block_last <= last;
    do @(posedge clk); while (!in_ready);
    decrypt_step(b, last, r, has);
    if (has) plain_q.push_back(known ? typed : r);
    phase_items++;
  endtask

  task automatic drain(input int extra);
    in_valid <= 1'b0;
    while (plain_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic logic [127:0] rnd128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Write all key registers while the block is idle
  task automatic load_key(input logic [1:0] len, input logic [63:0] k [4], input bit junk);
    logic [63:0] val;
    for (int i = 0; i < 5; i++) begin
      val = (i == 0) ? {(junk ? 62'({$urandom, $urandom}) : 62'h0), len} : k[i-1];
      cfg_we    <= 1'b1;
      cfg_index <= reg_ids[i];
      cfg_wdata <= val;
      @(posedge clk);
      if (i == 0) key_len = val[1:0];
      else key_reg[i-1] = val;
      expand_key();
    end
    cfg_we <= 1'b0;
  endtask

  // Send a parcel; unless it is raw or IV-only, the block before the last is chosen so
  // that the last block decrypts to the wanted padding
  task automatic send_parcel(input int nct, input int mode, input int pad);
    logic [127:0] blk [$];
    logic [127:0] p;
    int           j;
    for (int i = 0; i <= nct; i++) blk.push_back(rnd128());
    if (nct > 0 && mode != 3) begin
      p = rnd128();
      if (mode == 1) p[7:0] = 8'(pad);
      else for (int i = 0; i < pad; i++) p[8*i +: 8] = 8'(pad);
      if (mode == 2 && pad > 1) begin
        j = $urandom_range(1, pad - 1);
        p[8*j +: 8] ^= 8'($urandom_range(1, 255));
      end
      blk[nct-1] = aes_inverse(blk[nct]) ^ p;
    end
    for (int i = 0; i <= nct; i++) send_block(blk[i], i == nct);
  endtask

  // mode 0 good pad, 1 pad byte out of range, 2 corrupted pad, 3 raw
  task automatic random_parcel();
    int r;
    int nct;
    r = $urandom_range(99);
    nct = (r < 8) ? 0 : ((r < 90) ? $urandom_range(1, 3) : $urandom_range(4, 6));
    r = $urandom_range(99);
    if (r < 70) send_parcel(nct, 0, $urandom_range(1, 16));
    else if (r < 80) send_parcel(nct, 1, ($urandom_range(1) != 0) ? 0 : $urandom_range(17, 255));
    else if (r < 90) send_parcel(nct, 2, $urandom_range(2, 16));
    else send_parcel(nct, 3, 0);
  endtask

  // Receiver: check results, stall at random or hold off for a stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (plain_q.size() == 0) begin
          $display("%0t unexpected result: high %h low %h", $time, out_plain_high, out_plain_low);
          errors++;
        end else begin
          plain_res_t e;
          e = plain_q.pop_front();
          if (out_plain_high !== e.ph) begin
            $display("%0t plain_high: expected %h actual %h", $time, e.ph, out_plain_high);
            errors++;
          end
          if (out_plain_low !== e.pl) begin
            $display("%0t plain_low: expected %h actual %h", $time, e.pl, out_plain_low);
            errors++;
          end
          if (out_plain_last !== e.last) begin
            $display("%0t plain_last: expected %b actual %b", $time, e.last, out_plain_last);
            errors++;
          end
          if (out_valid_bytes !== e.vb) begin
            $display("%0t valid_bytes: expected %0d actual %0d", $time, e.vb, out_valid_bytes);
            errors++;
          end
          if (out_status !== e.st) begin
            $display("%0t status: expected %0d actual %0d", $time, e.st, out_status);
            errors++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL aes_cbc_decrypt_unpad_top");
      $finish;
    end
  end

  dir_row_t dir_tab [8] = '{
    '{128'h0, 1'b1, 1'b1, '{64'h0, 64'h0, 1'b1, 5'd0, ST_NOCT}},
    '{{128{1'b1}}, 1'b1, 1'b1, '{64'h0, 64'h0, 1'b1, 5'd0, ST_NOCT}},
    '{{128{1'b1}}, 1'b0, 1'b0, '{64'h0, 64'h0, 1'b0, 5'd0, ST_OK}},
    '{128'h0, 1'b0, 1'b0, '{64'h0, 64'h0, 1'b0, 5'd0, ST_OK}},
    '{{128{1'b1}}, 1'b1, 1'b0, '{64'h0, 64'h0, 1'b0, 5'd0, ST_OK}},
    '{128'h00112233_44556677_8899aabb_ccddeeff, 1'b0, 1'b0, '{64'h0, 64'h0, 1'b0, 5'd0, ST_OK}},
    '{128'h69c4e0d8_6a7b0430_d8cdb780_70b4c55a, 1'b1, 1'b0, '{64'h0, 64'h0, 1'b0, 5'd0, ST_OK}},
    '{128'h0, 1'b1, 1'b1, '{64'h0, 64'h0, 1'b1, 5'd0, ST_NOCT}}
  };

  initial begin
    logic [63:0] k [4];
    int          idle_tab [4][2];
    idle_tab = '{'{0, 0}, '{52, 0}, '{0, 52}, '{31, 31}};
    build_boxes();
    key_len = '0;
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    for (int i = 0; i < 30; i++) rnd_key[i] = '0;
    chain_blk = '0;
    await_iv = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all-zero 128-bit key, table rows then chosen paddings
    k = '{64'h0, 64'h0, 64'h0, 64'h0};
    load_key(2'd0, k, 1'b0);
    foreach (dir_tab[i]) send_block(dir_tab[i].blk, dir_tab[i].last, dir_tab[i].known, dir_tab[i].res);
    send_parcel(1, 0, 1);
    send_parcel(1, 0, 16);
    send_parcel(2, 1, 0);
    send_parcel(1, 1, 17);
    send_parcel(1, 2, 16);

    // Random phases over key sizes, key extremes and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      drain(DrainCycles);
      snd_idle_pct  = idle_tab[ph % 4][0];
      rcv_stall_pct = idle_tab[ph % 4][1];
      for (int i = 0; i < 4; i++) begin
        k[i] = (ph == 1) ? '0 : (ph == 2) ? '1 : {$urandom, $urandom};
      end
      load_key(2'(ph % 4), k, ph >= 4);
      phase_items = 0;
      if (ph == 4) begin
        // Hold the receiver off so the block fills and stalls its input
        hold_cnt = 400;
        repeat (12) send_parcel(3, 0, $urandom_range(1, 16));
      end
      while (phase_items < PhaseItems) begin
        random_parcel();
        if (ph == 5 && phase_items > 60 && phase_items < 66) drain(0);
      end
    end

    drain(DrainCycles);
    if (errors == 0) begin
      $display("PASS aes_cbc_decrypt_unpad_top");
    end else begin
      $display("FAIL aes_cbc_decrypt_unpad_top");
    end
    $finish;
  end

endmodule
